FILE: hw/rtl/smpq_pkg.sv
// Shared types and constants for the sorted max-priority queue.
// Used by the queue cells, the top level and the port checker; no dependencies.
package smpq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Operation code carried by an input transaction.
  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_e;

  // Status code returned with every result transaction.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY_ERR = 2'd2,
    ST_FULL_DROP = 2'd3
  } status_e;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic                     insert;
    logic                     extract;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic signed [ValueW-1:0] result_value;
    status_e                  status;
    logic [CountW-1:0]        count;
    logic                     is_empty;
  } rsp_t;

endpackage

FILE: hw/rtl/smpq_cell.sv
// One slot of the sorted chain: holds a value and moves it to a neighbor.
// Depends on smpq_pkg for the broadcast command type.
module smpq_cell import smpq_pkg::*; (
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic                     occupied_i,
  input  logic                     left_ge_i,
  input  logic signed [ValueW-1:0] left_value_i,
  input  logic signed [ValueW-1:0] right_value_i,
  output logic                     ge_o,
  output logic signed [ValueW-1:0] value_o
);

  logic signed [ValueW-1:0] value_q;
  logic signed [ValueW-1:0] value_d;
  logic                     load;

  // This slot holds a value at least as large as the one being inserted.
  assign ge_o = occupied_i && (value_q >= cmd_i.value);

  // Insert keeps values at least as large, takes the new value at the boundary and shifts
  // the rest down by one; extract shifts everything up by one.
  always_comb begin
    load    = 1'b0;
    value_d = value_q;
    if (cmd_i.extract) begin
      load    = 1'b1;
      value_d = right_value_i;
    end else if (cmd_i.insert && !ge_o) begin
      load    = 1'b1;
      value_d = left_ge_i ? cmd_i.value : left_value_i;
    end
  end

  // Payload register, no reset needed: occupancy comes from the count.
  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

FILE: hw/rtl/sorted_max_priority_queue.sv
// Bounded max-priority queue of signed 32-bit values, kept sorted in a chain
// of CAPACITY cells with the largest value in the first cell. For each insert or
// extract transaction the value is broadcast to all cells, each compares it with
// its own value and either keeps its value, takes the new one or takes a
// neighbor's, so one signed compare per cell sets the cycle. A new transaction
// is taken every cycle while the two-entry result buffer has room; every
// transaction yields exactly one result carrying the status, the count after
// the operation and an empty flag. Extract while empty and insert while full
// leave the contents unchanged and report an error status.
// Depends on smpq_pkg and smpq_cell.
module sorted_max_priority_queue import smpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] result_value_o,
  output logic [1:0]               status_o,
  output logic [CountW-1:0]        count_o,
  output logic                     is_empty_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;
  logic                     in_fire;
  logic                     is_full;
  logic                     is_empty;
  cell_cmd_t                cmd;
  rsp_t                     rsp;
  logic [CntW+CountW-1:0]   count_ext;

  logic [CAPACITY-1:0]                    occupied;
  logic [CAPACITY-1:0]                    ge;
  logic signed [CAPACITY-1:0][ValueW-1:0] cell_value;

  rsp_t out_q;
  rsp_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;
  logic out_fire;
  logic out_free;

  // Input handshake: a transaction is taken while the skid slot is empty.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign is_full    = (count_q == CntW'(CAPACITY));
  assign is_empty   = (count_q == '0);

  // Command to the cells, gated so a rejected operation changes nothing.
  always_comb begin
    cmd.value   = value_i;
    cmd.insert  = in_fire && (func_i == FUNC_INSERT) && !is_full;
    cmd.extract = in_fire && (func_i == FUNC_EXTRACT) && !is_empty;
  end

  // Chain of cells, largest value in cell 0.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     left_ge;
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    assign occupied[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_value = '0;
    end else begin : g_inner
      assign left_ge    = ge[g-1];
      assign left_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = cell_value[g+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occupied[g]),
      .left_ge_i    (left_ge),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .ge_o         (ge[g]),
      .value_o      (cell_value[g])
    );
  end

  // Next count and the result of the current transaction.
  always_comb begin
    count_d          = count_q;
    rsp.result_value = '0;
    rsp.status       = ST_INSERTED;
    if (func_i == FUNC_INSERT) begin
      if (is_full) begin
        rsp.status = ST_FULL_DROP;
      end else begin
        count_d    = count_q + CntW'(1);
        rsp.status = ST_INSERTED;
      end
    end else begin
      if (is_empty) begin
        rsp.status = ST_EMPTY_ERR;
      end else begin
        count_d          = count_q - CntW'(1);
        rsp.result_value = cell_value[0];
        rsp.status       = ST_EXTRACTED;
      end
    end
    count_ext    = {{CountW{1'b0}}, count_d};
    rsp.count    = count_ext[CountW-1:0];
    rsp.is_empty = (count_d == '0);
  end

  // Count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
    end
  end

  // Output register with a skid slot behind it.
  assign out_fire = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_q <= rsp;
      end else begin
        skid_q <= rsp;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q.result_value;
  assign status_o       = out_q.status;
  assign count_o        = out_q.count;
  assign is_empty_o     = out_q.is_empty;

endmodule

FILE: hw/rtl/smpq_checker.sv
// Port-level checks for the sorted max-priority queue, bound to the top level.
// Depends on smpq_pkg for the status codes.
module smpq_port_asserts import smpq_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [ValueW-1:0] result_value_o,
  input logic [1:0]               status_o,
  input logic [CountW-1:0]        count_o,
  input logic                     is_empty_o
);

  // A stalled result transaction stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o) &&
    $stable(status_o) && $stable(count_o))
    else $error("stalled result changed");

  // An empty queue always reports a zero count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> count_o == '0)
    else $error("empty flag with nonzero count");

  // Extract while empty returns zero and leaves the queue empty.
  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY_ERR |-> result_value_o == '0 && is_empty_o)
    else $error("bad extract-while-empty result");

  // Inserts, accepted or dropped, return zero and leave the queue nonempty.
  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_INSERTED || status_o == ST_FULL_DROP)
    |-> result_value_o == '0 && !is_empty_o)
    else $error("bad insert result");

endmodule

bind sorted_max_priority_queue smpq_port_asserts u_smpq_port_asserts (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_value_o(result_value_o),
  .status_o      (status_o),
  .count_o       (count_o),
  .is_empty_o    (is_empty_o)
);
